>>> rtl/cdc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdc_pkg
// Shared types, codes and lookup functions for the clock display controller.
// ----------------------------------------------------------------------------
package cdc_pkg;

    localparam int ANIMATION_COUNT = 3;

    localparam logic [1:0] OP_SECOND = 2'd0;
    localparam logic [1:0] OP_SCAN   = 2'd1;
    localparam logic [1:0] OP_BLANK  = 2'd2;

    localparam logic [1:0] SLOT_LED  = 2'd0;
    localparam logic [1:0] SLOT_ONES = 2'd1;
    localparam logic [1:0] SLOT_TENS = 2'd2;

    localparam logic [5:0] SECOND_LAST = 6'd58;
    localparam logic [5:0] MINUTE_LAST = 6'd58;
    localparam logic [4:0] HOUR_LAST   = 5'd22;
    localparam logic [7:0] ANIM_STRIDE = 8'd60;

    localparam logic [2:0] STABLE_MAX   = 3'd6;
    localparam logic [2:0] STABLE_LIMIT = 3'd5;

    localparam logic [6:0] BRIGHT_RESET = 7'h21;
    localparam logic [6:0] BRIGHT_TOP   = 7'h60;
    localparam logic [6:0] BRIGHT_STEP  = 7'h08;
    localparam logic [6:0] BRIGHT_FLOOR = 7'h08;

    localparam logic [7:0] SEG_DP = 8'h80;

    typedef struct packed {
        logic [1:0] operation;
        logic [2:0] button_pins;
    } item_t;

    typedef struct packed {
        logic [7:0] segments;
        logic [1:0] digit_select;
        logic [7:0] pattern_index;
        logic       pattern_slot;
        logic [6:0] brightness;
        logic       show_hours;
    } result_t;

    typedef struct packed {
        logic tick;
        logic step_minute;
        logic step_hour;
        logic show_minutes;
        logic show_hours;
    } time_cmd_t;

    function automatic logic [7:0] font(input logic [3:0] v);
        logic [7:0] seg;
        case (v)
            4'd0:    seg = 8'b00111111;
            4'd1:    seg = 8'b00000110;
            4'd2:    seg = 8'b01011011;
            4'd3:    seg = 8'h4F;
            4'd4:    seg = 8'h66;
            4'd5:    seg = 8'h6D;
            4'd6:    seg = 8'h7D;
            4'd7:    seg = 8'h07;
            4'd8:    seg = 8'h7F;
            4'd9:    seg = 8'b01101111;
            default: seg = 8'h00;
        endcase
        return seg;
    endfunction

    function automatic logic [3:0] tens_of(input logic [5:0] v);
        logic [3:0] t;
        if (v >= 6'd60)      t = 4'd6;
        else if (v >= 6'd50) t = 4'd5;
        else if (v >= 6'd40) t = 4'd4;
        else if (v >= 6'd30) t = 4'd3;
        else if (v >= 6'd20) t = 4'd2;
        else if (v >= 6'd10) t = 4'd1;
        else                 t = 4'd0;
        return t;
    endfunction

endpackage

>>> rtl/cdc_time.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdc_time
// Seconds, minutes, hours, animation counter and hours/minutes view.
// ----------------------------------------------------------------------------
module cdc_time (
    input  logic              clk,
    input  logic              rst_n,
    input  cdc_pkg::time_cmd_t cmd,
    output logic              hours_view,
    output logic [5:0]        digit_value,
    output logic              hours_view_next,
    output logic [7:0]        pattern_index_next
);
    import cdc_pkg::*;

    logic [5:0] second_reg, second_next;
    logic [5:0] minute_reg, minute_next;
    logic [4:0] hour_reg, hour_next;
    logic [1:0] anim_reg, anim_next;
    logic       phase_reg, phase_next;
    logic       view_reg, view_next;
    logic       minute_step;
    logic       hour_step;
    logic       animate;

    always_comb
    begin
        second_next = second_reg;
        minute_next = minute_reg;
        hour_next   = hour_reg;
        anim_next   = anim_reg;
        phase_next  = phase_reg;
        view_next   = view_reg;
        minute_step = cmd.step_minute;
        hour_step   = cmd.step_hour;
        animate     = 1'b0;

        if (cmd.tick)
        begin
            if (second_reg > SECOND_LAST)
            begin
                second_next = 6'd0;
                minute_step = 1'b1;
                animate     = 1'b1;
            end
            else
            begin
                second_next = second_reg + 6'd1;
            end
            if (phase_reg)
            begin
                phase_next = 1'b0;
                view_next  = ~view_reg;
            end
            else
            begin
                phase_next = 1'b1;
            end
        end

        if (minute_step)
        begin
            if (minute_reg > MINUTE_LAST)
            begin
                minute_next = 6'd0;
                hour_step   = 1'b1;
            end
            else
            begin
                minute_next = minute_reg + 6'd1;
                if (animate)
                begin
                    if (anim_reg >= 2'(ANIMATION_COUNT - 1))
                        anim_next = 2'd0;
                    else
                        anim_next = anim_reg + 2'd1;
                end
            end
        end

        if (hour_step)
        begin
            if (hour_reg > HOUR_LAST)
                hour_next = 5'd0;
            else
                hour_next = hour_reg + 5'd1;
        end

        if (cmd.show_minutes)
            view_next = 1'b0;
        if (cmd.show_hours)
            view_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            second_reg <= '0;
            minute_reg <= '0;
            hour_reg   <= '0;
            anim_reg   <= '0;
            phase_reg  <= 1'b0;
            view_reg   <= 1'b0;
        end
        else
        begin
            second_reg <= second_next;
            minute_reg <= minute_next;
            hour_reg   <= hour_next;
            anim_reg   <= anim_next;
            phase_reg  <= phase_next;
            view_reg   <= view_next;
        end
    end

    assign hours_view         = view_reg;
    assign digit_value        = view_reg ? {1'b0, hour_reg} : minute_reg;
    assign hours_view_next    = view_next;
    assign pattern_index_next = {2'b00, second_next} + ANIM_STRIDE * {6'd0, anim_next};

endmodule

>>> rtl/cdc_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdc_scan
// Display multiplexer: LED slot hold, ones digit and tens digit.
// ----------------------------------------------------------------------------
module cdc_scan (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       scan,
    input  logic       blank,
    input  logic       hours_view,
    input  logic [5:0] digit_value,
    output logic [7:0] segments_next,
    output logic [1:0] slot_next,
    output logic       rom_drive_next
);
    import cdc_pkg::*;

    logic [1:0] slot_reg;
    logic       hold_reg, hold_next;
    logic [7:0] seg_reg;
    logic       rom_reg;
    logic [3:0] tens;
    logic [5:0] ones;

    assign tens = tens_of(digit_value);
    assign ones = digit_value - 6'(tens) * 6'd10;

    always_comb
    begin
        slot_next      = slot_reg;
        hold_next      = hold_reg;
        segments_next  = seg_reg;
        rom_drive_next = rom_reg;
        if (scan)
        begin
            case (slot_reg)
                SLOT_LED:
                begin
                    if (hold_reg)
                    begin
                        segments_next  = 8'h00;
                        rom_drive_next = 1'b1;
                        hold_next      = 1'b0;
                    end
                    else
                    begin
                        slot_next      = SLOT_ONES;
                        segments_next  = font(ones[3:0]) | (hours_view ? 8'h00 : SEG_DP);
                        rom_drive_next = 1'b0;
                    end
                end
                SLOT_ONES:
                begin
                    slot_next      = SLOT_TENS;
                    segments_next  = font(tens);
                    rom_drive_next = 1'b0;
                end
                default:
                begin
                    slot_next      = SLOT_LED;
                    segments_next  = 8'h00;
                    rom_drive_next = 1'b1;
                    hold_next      = ~hold_reg;
                end
            endcase
        end
        else if (blank)
        begin
            segments_next  = 8'h00;
            rom_drive_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= SLOT_LED;
            hold_reg <= 1'b0;
            seg_reg  <= 8'h00;
            rom_reg  <= 1'b0;
        end
        else
        begin
            slot_reg <= slot_next;
            hold_reg <= hold_next;
            seg_reg  <= segments_next;
            rom_reg  <= rom_drive_next;
        end
    end

endmodule

>>> rtl/cdc_buttons.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdc_buttons
// Button debounce, command decode, arming and brightness level.
// ----------------------------------------------------------------------------
module cdc_buttons (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               sample,
    input  logic [2:0]         pins,
    output cdc_pkg::time_cmd_t cmd,
    output logic [6:0]         bright_next
);
    import cdc_pkg::*;

    logic [2:0] older_reg, older_next;
    logic [2:0] newer_reg, newer_next;
    logic [2:0] stable_reg, stable_next;
    logic [2:0] deb_reg, deb_next;
    logic       armed_reg, armed_next;
    logic [6:0] bright_reg;

    always_comb
    begin
        older_next  = older_reg;
        newer_next  = newer_reg;
        stable_next = stable_reg;
        deb_next    = deb_reg;
        armed_next  = armed_reg;
        bright_next = bright_reg;
        cmd         = '0;
        if (sample)
        begin
            older_next = newer_reg;
            newer_next = pins;
            if (newer_reg == pins)
            begin
                if (stable_reg < STABLE_MAX)
                    stable_next = stable_reg + 3'd1;
            end
            else
            begin
                stable_next = 3'd0;
            end
            if (stable_next > STABLE_LIMIT)
                deb_next = pins;

            if (armed_reg && !deb_next[0] && !deb_next[2])
            begin
                cmd.show_minutes = 1'b1;
                cmd.step_minute  = 1'b1;
                armed_next       = 1'b0;
            end
            else if (armed_reg && !deb_next[1] && !deb_next[2])
            begin
                cmd.show_hours = 1'b1;
                cmd.step_hour  = 1'b1;
                armed_next     = 1'b0;
            end
            else if (armed_reg && !deb_next[0])
            begin
                if (bright_reg < BRIGHT_TOP)
                    bright_next = bright_reg + BRIGHT_STEP;
                armed_next = 1'b0;
            end
            else if (armed_reg && !deb_next[1])
            begin
                if (bright_reg > BRIGHT_FLOOR)
                    bright_next = bright_reg - BRIGHT_STEP;
                armed_next = 1'b0;
            end
            else if (deb_next[0] && deb_next[1])
            begin
                armed_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            older_reg  <= '0;
            newer_reg  <= '0;
            stable_reg <= '0;
            deb_reg    <= '0;
            armed_reg  <= 1'b0;
            bright_reg <= BRIGHT_RESET;
        end
        else
        begin
            older_reg  <= older_next;
            newer_reg  <= newer_next;
            stable_reg <= stable_next;
            deb_reg    <= deb_next;
            armed_reg  <= armed_next;
            bright_reg <= bright_next;
        end
    end

endmodule

>>> rtl/clock_display_controller_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clock_display_controller_top
// Throughput: one transaction per cycle unless result_stall holds a valid
// result; input register, one pass of event logic, result register. A result
// becomes valid when its transaction leaves the input register.
// Reset: asynchronous, active low; clears all counters, selects the LED slot,
// sets brightness to 33 and empties both pipeline registers.
// ----------------------------------------------------------------------------
module clock_display_controller_top (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  cdc_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_stall,
    output cdc_pkg::result_t result
);
    import cdc_pkg::*;

    logic      s1_valid_reg;
    item_t     s1_item_reg;
    logic      out_valid_reg;
    result_t   out_reg;
    logic      advance;
    logic      fire;
    time_cmd_t btn_cmd;
    time_cmd_t time_cmd;
    logic      hours_view;
    logic [5:0] digit_value;
    logic      hours_view_next;
    logic [7:0] pattern_index_next;
    logic [7:0] segments_next;
    logic [1:0] slot_next;
    logic      rom_drive_next;
    logic [6:0] bright_next;

    assign advance    = !out_valid_reg || !result_stall;
    assign item_stall = s1_valid_reg && !advance;
    assign fire       = s1_valid_reg && advance;

    always_comb
    begin
        time_cmd      = btn_cmd;
        time_cmd.tick = fire && (s1_item_reg.operation == OP_SECOND);
    end

    cdc_time u_time (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (time_cmd),
        .hours_view         (hours_view),
        .digit_value        (digit_value),
        .hours_view_next    (hours_view_next),
        .pattern_index_next (pattern_index_next)
    );

    cdc_scan u_scan (
        .clk            (clk),
        .rst_n          (rst_n),
        .scan           (fire && (s1_item_reg.operation == OP_SCAN)),
        .blank          (fire && (s1_item_reg.operation == OP_BLANK)),
        .hours_view     (hours_view),
        .digit_value    (digit_value),
        .segments_next  (segments_next),
        .slot_next      (slot_next),
        .rom_drive_next (rom_drive_next)
    );

    cdc_buttons u_buttons (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample      (fire && (s1_item_reg.operation == OP_BLANK)),
        .pins        (s1_item_reg.button_pins),
        .cmd         (btn_cmd),
        .bright_next (bright_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!item_stall)
                s1_valid_reg <= item_valid;
            if (advance)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
            s1_item_reg <= item;
        if (fire)
        begin
            out_reg.segments      <= segments_next;
            out_reg.digit_select  <= slot_next;
            out_reg.pattern_index <= pattern_index_next;
            out_reg.pattern_slot  <= rom_drive_next;
            out_reg.brightness    <= bright_next;
            out_reg.show_hours    <= hours_view_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule
